/* rtl/toy_cpu_instruction_executor_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the instruction executor.
// Short wrappers around concurrent assertions with a common clock and reset.
// ---------------------------------------------------------------------------
`ifndef TOY_CPU_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define TOY_CPU_INSTRUCTION_EXECUTOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TCIE_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define TCIE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tcie_pkg.sv */
// ---------------------------------------------------------------------------
// tcie_pkg
// Shared sizes, codes, types and flag helper of the instruction executor.
// ---------------------------------------------------------------------------
`default_nettype none

package tcie_pkg;

   localparam int REG_COUNT   = 8;
   localparam int MEM_DEPTH   = 64;
   localparam int STACK_DEPTH = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int AW  = $clog2(MEM_DEPTH);
   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int QIW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   // Width of a full arithmetic result (8-bit times 17-bit signed product).
   localparam int RW = 25;
   // Width of the source operand (sign-extended 16-bit immediate plus one).
   localparam int SW = 17;
   localparam int DIV_STEPS = SW;
   localparam int DCW = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIVZ  = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [1:0] FS_CF = 2'd0;
   localparam logic [1:0] FS_OF = 2'd1;
   localparam logic [1:0] FS_UF = 2'd2;
   localparam logic [1:0] FS_ZF = 2'd3;

   localparam logic [1:0] KIND_IMM = 2'd0;
   localparam logic [1:0] KIND_REG = 2'd1;

   typedef enum logic [4:0] {
      OP_MOV, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INPUT,
      OP_DISPLAY, OP_INC, OP_DEC, OP_ROL, OP_ROR, OP_SHL, OP_SHR, OP_PUSH,
      OP_POP, OP_RESET, OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_EXEC, BK_DIV, BK_RESP
   } bk_state_type;

   typedef struct packed {
      op_type              op;
      logic [1:0]          operand_kind;
      logic                mem_direct;
      logic [2:0]          dest_index;
      logic [2:0]          source_index;
      logic [2:0]          pointer_index;
      logic signed [15:0]  immediate;
      logic [7:0]          direct_address;
      logic [2:0]          shift_amount;
      logic signed [15:0]  typed_value;
      logic [1:0]          flag_select;
   } instr_type;

   typedef struct packed {
      logic of;
      logic uf;
      logic cf;
      logic zf;
   } flags_type;

   function automatic flags_type flags_from(input logic signed [RW-1:0] r,
                                            input logic arith,
                                            input logic cf_old);
      flags_type f;
      f.of = r > RW'(127);
      f.uf = r < RW'(-128);
      f.zf = r == RW'(0);
      f.cf = arith ? ((r > RW'(255)) || (r < RW'(0))) : cf_old;
      return f;
   endfunction

endpackage

`default_nettype wire

/* rtl/tcie_if.sv */
// ---------------------------------------------------------------------------
// tcie_req_if / tcie_rsp_if
// Valid/ready channels for instruction requests and their results.
// ---------------------------------------------------------------------------
`default_nettype none

interface tcie_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         mode;
   logic [1:0]         operand_kind;
   logic [2:0]         dest_index;
   logic [2:0]         source_index;
   logic [2:0]         pointer_index;
   logic signed [15:0] immediate;
   logic [7:0]         direct_address;
   logic [7:0]         shift_count;
   logic signed [15:0] typed_value;
   logic [1:0]         flag_select;

   modport source (output valid, mode, operand_kind, dest_index, source_index,
                   pointer_index, immediate, direct_address, shift_count,
                   typed_value, flag_select, input ready);
   modport sink (input valid, mode, operand_kind, dest_index, source_index,
                 pointer_index, immediate, direct_address, shift_count,
                 typed_value, flag_select, output ready);
endinterface

interface tcie_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] shown_value;
   logic              shown_valid;
   logic [1:0]        status;
   logic              overflow_flag;
   logic              underflow_flag;
   logic              carry_flag;
   logic              zero_flag;
   logic [7:0]        program_counter;
   logic [4:0]        stack_fill;

   modport source (output valid, shown_value, shown_valid, status, overflow_flag,
                   underflow_flag, carry_flag, zero_flag, program_counter,
                   stack_fill, input ready);
   modport sink (input valid, shown_value, shown_valid, status, overflow_flag,
                 underflow_flag, carry_flag, zero_flag, program_counter,
                 stack_fill, output ready);
endinterface

`default_nettype wire

/* rtl/toy_cpu_instruction_executor.sv */
// ---------------------------------------------------------------------------
// toy_cpu_instruction_executor
// Executes one decoded instruction per request on a small 8-bit machine.
// ---------------------------------------------------------------------------
// Usage: each request on req_chan carries one decoded instruction, and the
// block returns exactly one result on rsp_chan for it, in order. A request
// is taken when valid and ready are both high at a rising clock edge.
// The front end classifies the opcode and drops it into a two-entry queue,
// so requests are still taken while the back end works or while a result
// waits for the receiver.
// Sequencing: a taken request waits in the queue until the back end pops
// it (operand fetch) into its instruction register; it executes in the
// EXEC state, where its result is registered and valid from then on. DIV
// with a nonzero divisor instead runs the one-bit-per-cycle divider and
// registers the quotient when it is done. A new instruction starts only
// after the previous result is taken, so the back end sequencer and the
// divider loop set the throughput; the back end holds one item at a time.
// Reset clears the registers, flags, program counter, stack count and the
// memory valid bits, so all memory reads as zero until written; no clearing
// pass is needed. When the receiver stalls, the result holds steady and the
// queue fills; then ready drops until the back end moves on.
// ---------------------------------------------------------------------------
`default_nettype none

module toy_cpu_instruction_executor (
   input  wire logic   clock,
   input  wire logic   reset,
   tcie_req_if.sink    req_chan,
   tcie_rsp_if.source  rsp_chan
);

   // Front end to queue.
   logic                push_valid;
   tcie_pkg::instr_type push_data;
   logic                queue_full;

   // Queue to back end.
   logic                head_valid;
   tcie_pkg::instr_type head;
   logic                pop;

   tcie_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   tcie_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // The back end owns all machine state and the result register.
   tcie_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

/* rtl/tcie_front.sv */
// ---------------------------------------------------------------------------
// tcie_front
// Accepts instruction requests and classifies the opcode for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tcie_front (
   tcie_req_if.sink          req_chan,
   input  wire logic         queue_full,
   output logic              push_valid,
   output tcie_pkg::instr_type push_data
);

   tcie_pkg::op_type op;

   always_comb begin
      unique case (req_chan.mode)
         5'd0:    op = tcie_pkg::OP_MOV;
         5'd1:    op = tcie_pkg::OP_LOAD;
         5'd2:    op = tcie_pkg::OP_STORE;
         5'd3:    op = tcie_pkg::OP_ADD;
         5'd4:    op = tcie_pkg::OP_SUB;
         5'd5:    op = tcie_pkg::OP_MUL;
         5'd6:    op = tcie_pkg::OP_DIV;
         5'd7:    op = tcie_pkg::OP_INPUT;
         5'd8:    op = tcie_pkg::OP_DISPLAY;
         5'd9:    op = tcie_pkg::OP_INC;
         5'd10:   op = tcie_pkg::OP_DEC;
         5'd11:   op = tcie_pkg::OP_ROL;
         5'd12:   op = tcie_pkg::OP_ROR;
         5'd13:   op = tcie_pkg::OP_SHL;
         5'd14:   op = tcie_pkg::OP_SHR;
         5'd15:   op = tcie_pkg::OP_PUSH;
         5'd16:   op = tcie_pkg::OP_POP;
         5'd17:   op = tcie_pkg::OP_RESET;
         default: op = tcie_pkg::OP_NOP;
      endcase
   end

   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full;

   always_comb begin
      push_data.op             = op;
      push_data.operand_kind   = req_chan.operand_kind;
      // Loads and stores with kind zero use the address carried in the request.
      push_data.mem_direct     = ((op == tcie_pkg::OP_LOAD) || (op == tcie_pkg::OP_STORE))
                                 && (req_chan.operand_kind == tcie_pkg::KIND_IMM);
      push_data.dest_index     = req_chan.dest_index;
      push_data.source_index   = req_chan.source_index;
      push_data.pointer_index  = req_chan.pointer_index;
      push_data.immediate      = req_chan.immediate;
      push_data.direct_address = req_chan.direct_address;
      push_data.shift_amount   = req_chan.shift_count[2:0];
      push_data.typed_value    = req_chan.typed_value;
      push_data.flag_select    = req_chan.flag_select;
   end

endmodule

`default_nettype wire

/* rtl/tcie_queue.sv */
// ---------------------------------------------------------------------------
// tcie_queue
// Short instruction queue between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tcie_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tcie_pkg::instr_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output tcie_pkg::instr_type      head
);

   tcie_pkg::instr_type            entry_ff [tcie_pkg::QUEUE_DEPTH];
   logic [tcie_pkg::QIW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcie_pkg::QIW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcie_pkg::QCW-1:0]       count_ff, count_in;

   assign full       = count_ff == tcie_pkg::QCW'(tcie_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? tcie_pkg::QIW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? tcie_pkg::QIW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/tcie_divider.sv */
// ---------------------------------------------------------------------------
// tcie_divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module tcie_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [tcie_pkg::SW-1:0]   num,
   input  wire logic signed [7:0]                den,
   output logic                                  done,
   output logic signed [tcie_pkg::RW-1:0]        quo
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [tcie_pkg::DCW-1:0]    cnt_ff, cnt_in;
   logic [tcie_pkg::SW-1:0]     n_ff, n_in;
   logic [tcie_pkg::SW-1:0]     q_ff, q_in;
   logic [7:0]                  d_ff, d_in;
   logic [8:0]                  rem_ff, rem_in;
   logic                        neg_ff, neg_in;
   logic [8:0]                  rem_sh;
   logic                        take;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[7:0], n_ff[tcie_pkg::SW-1]};
      take    = rem_sh >= {1'b0, d_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = num[tcie_pkg::SW-1] ? tcie_pkg::SW'(-num) : num;
         d_in    = den[7] ? 8'(-den) : den;
         rem_in  = '0;
         q_in    = '0;
         neg_in  = num[tcie_pkg::SW-1] ^ den[7];
      end else if (busy_ff) begin
         rem_in = take ? 9'(rem_sh - {1'b0, d_ff}) : rem_sh;
         q_in   = {q_ff[tcie_pkg::SW-2:0], take};
         n_in   = {n_ff[tcie_pkg::SW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tcie_pkg::DCW'(tcie_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -tcie_pkg::RW'(q_ff) : tcie_pkg::RW'(q_ff);

endmodule

`default_nettype wire

/* rtl/tcie_back.sv */
// ---------------------------------------------------------------------------
// tcie_back
// Executes queued instructions against registers, flags, memory and stack.
// ---------------------------------------------------------------------------
`default_nettype none

`include "toy_cpu_instruction_executor_assert.svh"

module tcie_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire tcie_pkg::instr_type head,
   output logic                     pop,
   tcie_rsp_if.source               rsp_chan
);

   localparam int RW = tcie_pkg::RW;
   localparam int SW = tcie_pkg::SW;

   tcie_pkg::bk_state_type       state_ff, state_in;
   tcie_pkg::instr_type          cur_ff;
   logic [7:0]                   regs_ff [tcie_pkg::REG_COUNT];
   tcie_pkg::flags_type          flags_ff, flags_in;
   logic [7:0]                   mem [tcie_pkg::MEM_DEPTH];
   logic [tcie_pkg::MEM_DEPTH-1:0] mem_valid_ff;
   logic [7:0]                   stack_mem [tcie_pkg::STACK_DEPTH];
   logic [tcie_pkg::SPW-1:0]     sp_ff, sp_in, sp_m1;
   logic [7:0]                   pc_ff;
   logic [tcie_pkg::AW-1:0]      addr_ff, rd_addr;
   logic [7:0]                   rdd_ff, stk_rd_ff;
   logic                         rdv_ff;

   logic                         exec_en, div_go, div_commit, commit;
   logic                         div_done;
   logic signed [RW-1:0]         div_quo;

   logic signed [7:0]            dv, memval;
   logic signed [SW-1:0]         sv;
   logic signed [RW-1:0]         dv_w, sv_w, r_arith;
   logic [15:0]                  rot2;
   logic [7:0]                   sh_val;
   logic                         wr_en;
   logic [7:0]                   wr_val;
   logic [1:0]                   status;
   logic                         mem_we, push_we;
   logic                         show;

   logic signed [7:0]            shown_value_ff;
   logic                         shown_valid_ff;
   logic [1:0]                   status_ff;
   tcie_pkg::flags_type          rsp_flags_ff;
   logic [7:0]                   rsp_pc_ff;
   logic [4:0]                   rsp_fill_ff;

   // ---------------- control -----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcie_pkg::BK_IDLE: begin
            if (head_valid) state_in = tcie_pkg::BK_EXEC;
         end
         tcie_pkg::BK_EXEC: begin
            state_in = div_go ? tcie_pkg::BK_DIV : tcie_pkg::BK_RESP;
         end
         tcie_pkg::BK_DIV: begin
            if (div_done) state_in = tcie_pkg::BK_RESP;
         end
         tcie_pkg::BK_RESP: begin
            if (rsp_chan.ready) state_in = tcie_pkg::BK_IDLE;
         end
         default: state_in = tcie_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop            = (state_ff == tcie_pkg::BK_IDLE) && head_valid;
      exec_en        = state_ff == tcie_pkg::BK_EXEC;
      div_go         = exec_en && (cur_ff.op == tcie_pkg::OP_DIV) && (dv != 8'sd0);
      div_commit     = (state_ff == tcie_pkg::BK_DIV) && div_done;
      commit         = (exec_en && !div_go) || div_commit;
      rsp_chan.valid = state_ff == tcie_pkg::BK_RESP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcie_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- operand fetch -----------------
   assign rd_addr = head.mem_direct ? head.direct_address[tcie_pkg::AW-1:0]
                                    : regs_ff[head.pointer_index][tcie_pkg::AW-1:0];
   assign sp_m1   = sp_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff    <= head;
         addr_ff   <= rd_addr;
         rdd_ff    <= mem[rd_addr];
         rdv_ff    <= mem_valid_ff[rd_addr];
         stk_rd_ff <= stack_mem[sp_m1[tcie_pkg::SIW-1:0]];
      end
      if (mem_we) begin
         mem[addr_ff] <= regs_ff[cur_ff.dest_index];
      end
      if (push_we) begin
         stack_mem[sp_ff[tcie_pkg::SIW-1:0]] <= regs_ff[cur_ff.dest_index];
      end
   end

   // ---------------- execute -----------------
   always_comb begin
      dv     = regs_ff[cur_ff.dest_index];
      memval = rdv_ff ? rdd_ff : 8'sd0;
      case (cur_ff.operand_kind)
         tcie_pkg::KIND_IMM: sv = SW'(cur_ff.immediate);
         tcie_pkg::KIND_REG: sv = SW'($signed(regs_ff[cur_ff.source_index]));
         default:            sv = SW'(memval);
      endcase
      dv_w = RW'(dv);
      sv_w = RW'(sv);
      rot2 = {dv, dv};
      case (cur_ff.op)
         tcie_pkg::OP_ADD: r_arith = dv_w + sv_w;
         tcie_pkg::OP_SUB: r_arith = dv_w - sv_w;
         tcie_pkg::OP_MUL: r_arith = dv_w * sv_w;
         tcie_pkg::OP_INC: r_arith = dv_w + RW'(1);
         default:          r_arith = dv_w - RW'(1);
      endcase
      case (cur_ff.op)
         tcie_pkg::OP_ROL: sh_val = 8'(rot2 << cur_ff.shift_amount >> 8);
         tcie_pkg::OP_ROR: sh_val = 8'(rot2 >> cur_ff.shift_amount);
         tcie_pkg::OP_SHL: sh_val = 8'(dv << cur_ff.shift_amount);
         default:          sh_val = 8'($unsigned(dv) >> cur_ff.shift_amount);
      endcase
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_val   = '0;
      flags_in = flags_ff;
      status   = tcie_pkg::ST_OK;
      mem_we   = 1'b0;
      push_we  = 1'b0;
      sp_in    = sp_ff;
      show     = 1'b0;
      if (div_commit) begin
         wr_en    = 1'b1;
         wr_val   = div_quo[7:0];
         flags_in = tcie_pkg::flags_from(div_quo, 1'b1, flags_ff.cf);
      end else if (exec_en) begin
         unique case (cur_ff.op)
            tcie_pkg::OP_MOV: begin
               wr_en    = 1'b1;
               wr_val   = sv[7:0];
               flags_in = tcie_pkg::flags_from(sv_w, 1'b0, flags_ff.cf);
            end
            tcie_pkg::OP_LOAD: begin
               wr_en    = 1'b1;
               wr_val   = memval;
               flags_in = tcie_pkg::flags_from(RW'(memval), 1'b0, flags_ff.cf);
            end
            tcie_pkg::OP_STORE: mem_we = 1'b1;
            tcie_pkg::OP_ADD, tcie_pkg::OP_SUB, tcie_pkg::OP_MUL,
            tcie_pkg::OP_INC, tcie_pkg::OP_DEC: begin
               wr_en    = 1'b1;
               wr_val   = r_arith[7:0];
               flags_in = tcie_pkg::flags_from(r_arith, 1'b1, flags_ff.cf);
            end
            tcie_pkg::OP_DIV: begin
               if (dv == 8'sd0) status = tcie_pkg::ST_DIVZ;
            end
            tcie_pkg::OP_INPUT: begin
               wr_en    = 1'b1;
               wr_val   = cur_ff.typed_value[7:0];
               flags_in = tcie_pkg::flags_from(RW'(cur_ff.typed_value), 1'b0,
                                               flags_ff.cf);
            end
            tcie_pkg::OP_DISPLAY: show = 1'b1;
            tcie_pkg::OP_ROL, tcie_pkg::OP_ROR, tcie_pkg::OP_SHL, tcie_pkg::OP_SHR: begin
               wr_en    = 1'b1;
               wr_val   = sh_val;
               flags_in = tcie_pkg::flags_from(RW'($signed(sh_val)), 1'b0, flags_ff.cf);
            end
            tcie_pkg::OP_PUSH: begin
               if (sp_ff >= tcie_pkg::SPW'(tcie_pkg::STACK_DEPTH)) begin
                  status = tcie_pkg::ST_FULL;
               end else begin
                  push_we = 1'b1;
                  sp_in   = sp_ff + 1'b1;
               end
            end
            tcie_pkg::OP_POP: begin
               if (sp_ff == '0) begin
                  status = tcie_pkg::ST_UNDER;
               end else begin
                  wr_en    = 1'b1;
                  wr_val   = stk_rd_ff;
                  sp_in    = sp_m1;
                  flags_in = tcie_pkg::flags_from(RW'($signed(stk_rd_ff)), 1'b0,
                                                  flags_ff.cf);
               end
            end
            tcie_pkg::OP_RESET: begin
               unique case (cur_ff.flag_select)
                  tcie_pkg::FS_CF: flags_in.cf = 1'b0;
                  tcie_pkg::FS_OF: flags_in.of = 1'b0;
                  tcie_pkg::FS_UF: flags_in.uf = 1'b0;
                  default:         flags_in.zf = 1'b0;
               endcase
            end
            default: ;
         endcase
      end
   end

   tcie_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (sv),
      .den   (dv),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---------------- architectural state -----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcie_pkg::REG_COUNT; i++) regs_ff[i] <= '0;
         flags_ff     <= '0;
         mem_valid_ff <= '0;
         sp_ff        <= '0;
         pc_ff        <= '0;
      end else begin
         if (wr_en) regs_ff[cur_ff.dest_index] <= wr_val;
         if (mem_we) mem_valid_ff[addr_ff] <= 1'b1;
         if (commit) begin
            flags_ff <= flags_in;
            sp_ff    <= sp_in;
            pc_ff    <= pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         shown_value_ff <= show ? dv : 8'sd0;
         shown_valid_ff <= show;
         status_ff      <= status;
         rsp_flags_ff   <= flags_in;
         rsp_pc_ff      <= pc_ff + 1'b1;
         rsp_fill_ff    <= 5'(sp_in);
      end
   end

   assign rsp_chan.shown_value     = shown_value_ff;
   assign rsp_chan.shown_valid     = shown_valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.overflow_flag   = rsp_flags_ff.of;
   assign rsp_chan.underflow_flag  = rsp_flags_ff.uf;
   assign rsp_chan.carry_flag      = rsp_flags_ff.cf;
   assign rsp_chan.zero_flag       = rsp_flags_ff.zf;
   assign rsp_chan.program_counter = rsp_pc_ff;
   assign rsp_chan.stack_fill      = rsp_fill_ff;

   // ---------------- assertions -----------------
   `TCIE_ASSERT_ALWAYS(a_sp_bound, clock, reset,
      sp_ff <= tcie_pkg::SPW'(tcie_pkg::STACK_DEPTH), "stack count beyond depth")
   `TCIE_ASSERT_NEXT(a_pc_step, clock, reset, commit,
      pc_ff == $past(pc_ff) + 8'd1, "program counter did not advance on commit")
   `TCIE_ASSERT_NEXT(a_push_grow, clock, reset, push_we,
      sp_ff == $past(sp_ff) + 1'b1, "push did not grow the stack")
   `TCIE_ASSERT_ALWAYS(a_div_den, clock, reset,
      !div_go || (dv != 8'sd0), "divider started with zero divisor")

endmodule

`default_nettype wire
